@@ rtl/core/alist_pkg.sv @@
// Shared types and constants for the array list block.
// Holds command, status and datapath control codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alist_pkg;

  localparam int CMD_W     = 2;
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 2;
  localparam int CNT_W     = 7;
  localparam int CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BEYOND    = 2'd3
  } status_t;

  // per-cycle datapath operation
  typedef enum logic [2:0] {
    DP_IDLE,
    DP_LOAD,
    DP_SCAN,
    DP_UP,
    DP_DN,
    DP_FIN
  } dp_op_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_INC,
    UPD_DEC
  } upd_t;

  typedef enum logic [1:0] {
    ISEL_ZERO,
    ISEL_POS,
    ISEL_HIT
  } isel_t;

  typedef struct packed {
    dp_op_t  op;
    status_t st;
    upd_t    upd;
    isel_t   isel;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic beyond;
    logic hit;
    logic walk_end;
    logic o_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/alist_dp.sv @@
// Datapath of the array list: entry memory, walk counters, count and result register.
// Executes one operation per cycle as chosen by alist_ctrl; uses alist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alist_dp #(
  parameter int DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [alist_pkg::CAP_W-1:0]  cap,
  input  wire logic [alist_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [alist_pkg::POS_W-1:0]  in_position,
  input  wire logic [alist_pkg::VAL_W-1:0]  in_value,
  input  wire alist_pkg::ctl_t              ctl,
  output alist_pkg::sts_t                   sts,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [alist_pkg::ST_W-1:0]        out_status,
  output logic [alist_pkg::POS_W-1:0]       out_found_index,
  output logic [alist_pkg::CNT_W-1:0]       out_entry_count,
  output logic                              out_empty_flag,
  output logic                              out_full_flag
);
  import alist_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (AW > CNT_W) ? AW : CNT_W;
  localparam logic [XW:0] DEPTH_X = (XW+1)'(DEPTH);

  logic [VAL_W-1:0] mem [DEPTH];

  cmd_t             cmd_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [XW-1:0]    ra_r;
  logic [XW-1:0]    wa_r;
  logic [XW-1:0]    hidx_r;
  logic [VAL_W-1:0] rq_r;
  logic             rv_r;

  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [POS_W-1:0] out_idx_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_empty_r;
  logic             out_full_r;

  logic [XW-1:0]    count_x;
  logic [XW-1:0]    pos_x;
  logic [XW:0]      cap_x;
  logic [XW:0]      eff_cap;
  logic             full_now;
  logic             hit_now;
  logic             rd_go;
  logic [AW-1:0]    rd_addr;
  logic [XW-1:0]    dest;
  logic [XW-1:0]    ra_step;
  logic [XW-1:0]    ra_dec;
  logic             wr_go;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic [POS_W-1:0] idx_sel;

  assign count_x = XW'(count_r);
  assign pos_x   = XW'(pos_r);
  assign cap_x   = (XW+1)'(cap);
  assign eff_cap = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
  assign full_now = {1'b0, count_x} >= eff_cap;
  assign hit_now  = (ctl.op == DP_SCAN) && rv_r && (rq_r == val_r);
  assign ra_dec   = ra_r - XW'(1);

  // read side and write side of the walk
  always_comb begin
    rd_go   = 1'b0;
    rd_addr = ra_r[AW-1:0];
    dest    = ra_r;
    ra_step = ra_r + XW'(1);
    wr_go   = 1'b0;
    wr_addr = wa_r[AW-1:0];
    wr_data = rq_r;
    case (ctl.op) inside
      DP_SCAN: begin
        rd_go = (ra_r < count_x) && !hit_now;
      end
      DP_DN: begin
        rd_go = ra_r < count_x;
        dest  = ra_dec;
        wr_go = rv_r;
      end
      DP_UP: begin
        // ra_r is one above the read index here
        rd_go   = ra_r > pos_x;
        rd_addr = ra_dec[AW-1:0];
        ra_step = ra_dec;
        wr_go   = rv_r;
      end
      DP_FIN: begin
        wr_go   = ctl.upd == UPD_INC;
        wr_addr = pos_x[AW-1:0];
        wr_data = val_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (ctl.upd)
      UPD_INC: count_nxt = count_r + CNT_W'(1);
      UPD_DEC: count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
    case (ctl.isel)
      ISEL_POS: idx_sel = pos_r;
      ISEL_HIT: idx_sel = hidx_r[POS_W-1:0];
      default:  idx_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_go) begin
      rq_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r        <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (ctl.op) inside
        DP_LOAD: begin
          rv_r <= 1'b0;
        end
        DP_SCAN, DP_UP, DP_DN: begin
          rv_r <= rd_go && !hit_now;
        end
        DP_FIN: begin
          count_r <= count_nxt;
        end
        default: ;
      endcase
      if (ctl.op == DP_FIN) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op) inside
      DP_LOAD: begin
        cmd_r <= cmd_t'(in_cmd);
        pos_r <= in_position;
        val_r <= in_value;
        ra_r  <= (in_cmd == CMD_INSERT) ? count_x : '0;
      end
      DP_SCAN, DP_UP, DP_DN: begin
        if (hit_now) begin
          // first match: park the index and aim the walk just past it
          hidx_r <= wa_r;
          ra_r   <= wa_r + XW'(1);
        end else if (rd_go) begin
          wa_r <= dest;
          ra_r <= ra_step;
        end
      end
      DP_FIN: begin
        out_status_r <= ctl.st;
        out_idx_r    <= idx_sel;
        out_cnt_r    <= count_nxt;
        out_empty_r  <= count_nxt == '0;
        out_full_r   <= {1'b0, XW'(count_nxt)} >= eff_cap;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.cmd      = cmd_r;
    sts.full     = full_now;
    sts.beyond   = pos_x > count_x;
    sts.hit      = hit_now;
    sts.walk_end = !rv_r && ((ctl.op == DP_UP) ? (ra_r <= pos_x) : (ra_r >= count_x));
    sts.o_free   = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_idx_r;
  assign out_entry_count = out_cnt_r;
  assign out_empty_flag  = out_empty_r;
  assign out_full_flag   = out_full_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_x} <= DEPTH_X)
    else $error("entry count above storage depth");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == DP_FIN |=> out_valid_r)
    else $error("result not presented after finish");

  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == DP_FIN) && (ctl.upd == UPD_INC) |-> !full_now)
    else $error("insert committed into a full list");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == DP_FIN) && (ctl.upd == UPD_DEC) |-> count_r != '0)
    else $error("remove committed on an empty list");

endmodule

`default_nettype wire

@@ rtl/core/alist_ctrl.sv @@
// Controller of the array list: sequences load, check, scan, shift and finish.
// Drives alist_dp through ctl_t and reads back sts_t; uses alist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alist_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire alist_pkg::sts_t  sts,
  output alist_pkg::ctl_t       ctl
);
  import alist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_UP,
    S_DN,
    S_FIN
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  upd_t    upd_r, upd_nxt;
  isel_t   isel_r, isel_nxt;
  dp_op_t  op;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    upd_nxt   = upd_r;
    isel_nxt  = isel_r;
    op        = DP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = DP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        st_nxt   = ST_OK;
        upd_nxt  = UPD_NONE;
        isel_nxt = ISEL_ZERO;
        unique case (sts.cmd)
          CMD_INSERT: begin
            // fullness wins over a bad position
            if (sts.full) begin
              st_nxt    = ST_FULL;
              state_nxt = S_FIN;
            end else if (sts.beyond) begin
              st_nxt    = ST_BEYOND;
              state_nxt = S_FIN;
            end else begin
              upd_nxt   = UPD_INC;
              isel_nxt  = ISEL_POS;
              state_nxt = S_UP;
            end
          end
          CMD_REMOVE: begin
            upd_nxt   = UPD_DEC;
            isel_nxt  = ISEL_HIT;
            state_nxt = S_SCAN;
          end
          CMD_SEARCH: begin
            isel_nxt  = ISEL_HIT;
            state_nxt = S_SCAN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        op = DP_SCAN;
        if (sts.hit) begin
          state_nxt = (sts.cmd == CMD_REMOVE) ? S_DN : S_FIN;
        end else if (sts.walk_end) begin
          st_nxt    = ST_NOT_FOUND;
          upd_nxt   = UPD_NONE;
          isel_nxt  = ISEL_ZERO;
          state_nxt = S_FIN;
        end
      end
      S_UP: begin
        op = DP_UP;
        if (sts.walk_end) begin
          state_nxt = S_FIN;
        end
      end
      S_DN: begin
        op = DP_DN;
        if (sts.walk_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the result register can take the beat
        if (sts.o_free) begin
          op        = DP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
      upd_r   <= UPD_NONE;
      isel_r  <= ISEL_ZERO;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      upd_r   <= upd_nxt;
      isel_r  <= isel_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    ctl.op   = op;
    ctl.st   = st_r;
    ctl.upd  = upd_r;
    ctl.isel = isel_r;
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DISP)
    else $error("accepted beat not dispatched");

  a_fin_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && sts.o_free |=> state_r == S_IDLE)
    else $error("finish did not return to idle");

  a_inc_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (op == DP_FIN) && (upd_r == UPD_INC) |-> (sts.cmd == CMD_INSERT) && (st_r == ST_OK))
    else $error("count increment outside a good insert");

endmodule

`default_nettype wire

@@ rtl/core/array_list_insert_remove_search.sv @@
// Top level of the array list: configuration register, controller and datapath.
// Instantiates alist_ctrl and alist_dp; uses alist_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit entries held in a single-port-read,
// single-port-write memory. One command is in work at a time; a new beat is taken
// while the previous result still waits on the output register. The time a command
// takes is set by the memory walk (one entry read per cycle): a search that hits
// stops at the match, a search or remove that misses reads every entry, an insert
// shifts the entries at and above its position up one place (none for an append),
// a successful remove scans to the match and then shifts the later entries down one
// place, and a refused insert or the unused command skips the walk. A result that
// cannot leave the output register holds the finish step. Capacity (register 0,
// reset 64) saturates at DEPTH. Entries above the count are never read, so the
// memory needs no clearing after reset.
module array_list_insert_remove_search #(
  parameter int DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [alist_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [alist_pkg::POS_W-1:0]  in_position,
  input  wire logic [alist_pkg::VAL_W-1:0]  in_value,

  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [alist_pkg::ST_W-1:0]        out_status,
  output logic [alist_pkg::POS_W-1:0]       out_found_index,
  output logic [alist_pkg::CNT_W-1:0]       out_entry_count,
  output logic                              out_empty_flag,
  output logic                              out_full_flag,

  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [2:0]                   cfg_paddr,
  input  wire logic [31:0]                  cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import alist_pkg::*;

  localparam logic REG_CAP = 1'b0;

  logic [CAP_W-1:0] cap_r;
  logic             cfg_wr;
  ctl_t             ctl;
  sts_t             sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_CAP)) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_CAP) ? 32'(cap_r) : '0;

  alist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  alist_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cap             (cap_r),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_value        (in_value),
    .ctl             (ctl),
    .sts             (sts),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_entry_count (out_entry_count),
    .out_empty_flag  (out_empty_flag),
    .out_full_flag   (out_full_flag)
  );

endmodule

`default_nettype wire
